@@ rtl/xcfd_pkg.sv @@
// shared constants and types for the xor-checked frame deframer
// no dependencies; imported by every module of the block
package xcfd_pkg;

   localparam int BYTE_W        = 8;
   localparam int CFG_W         = 7;
   localparam int IDX_W         = 6;
   localparam int RSP_DATA_W    = 24;
   localparam int BUF_DEPTH_DEF = 64;

   localparam logic [CFG_W-1:0]  MAX_PAYLOAD_RST = 7'd64;

   localparam logic [BYTE_W-1:0] SYNC_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] SYNC_M      = 8'h4D;
   localparam logic [BYTE_W-1:0] SYNC_LT     = 8'h3C;

   typedef struct packed {
      logic              last;
      logic              has_payload;
      logic [IDX_W-1:0]  byte_index;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] command_code;
   } rsp_item_type;

endpackage

@@ rtl/xor_checked_frame_deframer_core.sv @@
// Request-frame deframer: '$' 'M' '<' size command payload checksum.
// Channels: req_* takes one received byte per beat; rsp_* gives one beat per
// payload byte of a good frame (command, byte, index, last), or a single beat
// with has_payload low for an empty frame; csr_* writes max_payload.
// Header, size and payload bytes are taken at one beat per cycle; payload
// bytes go into a BUF_DEPTH-entry buffer memory as they arrive.
// After the checksum byte of a good frame the buffer is read back: each
// result is read from the memory in ST_RD and loaded into the output register
// in ST_LD; the next byte is read only once that result has been loaded.
// req_tready is low during that read-back; the last result may still wait in
// the output register while the next frame's bytes are taken.
// A stalled receiver holds the output register; read-back pauses with it.
// A bad checksum, a header mismatch or a size above max_payload (clamped to
// BUF_DEPTH) drops the frame with no output.
// Reset returns the parser to idle, drops any waiting result and sets
// max_payload to 64; the buffer needs no clearing.
// depends on xcfd_pkg and xcfd_payload_ram
module xor_checked_frame_deframer_core #(
   parameter int BUF_DEPTH = xcfd_pkg::BUF_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: rx_byte [7:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [xcfd_pkg::BYTE_W-1:0]       req_tdata,
   // tdata: command_code [7:0], payload_byte [15:8], byte_index [21:16], zero [23:22]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [xcfd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: has_payload [0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [xcfd_pkg::CFG_W-1:0]        csr_data
);
   import xcfd_pkg::*;

   localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CNT_W  = CFG_W;
   localparam int LIM_W  = 9;
   localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(BUF_DEPTH);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DOLLAR = 3'd1;
   localparam logic [2:0] ST_M      = 3'd2;
   localparam logic [2:0] ST_SIZE   = 3'd3;
   localparam logic [2:0] ST_CMD    = 3'd4;
   localparam logic [2:0] ST_DATA   = 3'd5;
   localparam logic [2:0] ST_RD     = 3'd6;
   localparam logic [2:0] ST_LD     = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [CFG_W-1:0]   max_pay_ff, max_pay_in;
   logic [CNT_W-1:0]   exp_size_ff, exp_size_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]  csum_ff, csum_in;
   logic [BYTE_W-1:0]  cmd_ff, cmd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic               req_fire;
   logic [LIM_W-1:0]   size_lim;
   logic               oversize;
   logic               store_ok;
   logic               more;
   logic [CNT_W-1:0]   cnt_inc;
   logic               last_k;
   logic               empty_frame;
   logic               out_free;
   logic               load_out;
   logic [CNT_W+ADDR_W-1:0] cnt_ext;
   logic [ADDR_W-1:0]  buf_addr;
   logic               wr_en;
   logic               rd_en;
   logic [BYTE_W-1:0]  rd_data;

   assign req_tready = (state_ff != ST_RD) && (state_ff != ST_LD);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // effective limit is max_payload clamped to the buffer depth
   assign size_lim = (LIM_W'(max_pay_ff) > DEPTH_L) ? DEPTH_L : LIM_W'(max_pay_ff);
   assign oversize = LIM_W'(req_tdata) > size_lim;
   assign store_ok = LIM_W'(count_ff) < DEPTH_L;
   assign more     = count_ff < exp_size_ff;
   assign cnt_inc  = count_ff + 7'd1;
   assign last_k   = cnt_inc == exp_size_ff;
   assign empty_frame = exp_size_ff == '0;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_out = (state_ff == ST_LD) && out_free;

   assign cnt_ext  = (CNT_W+ADDR_W)'(count_ff);
   assign buf_addr = cnt_ext[ADDR_W-1:0];
   assign wr_en    = (state_ff == ST_DATA) && req_fire && more && store_ok;
   assign rd_en    = state_ff == ST_RD;

   xcfd_payload_ram #(
      .DEPTH  (BUF_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (buf_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (buf_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      exp_size_in = exp_size_ff;
      count_in    = count_ff;
      csum_in     = csum_ff;
      cmd_in      = cmd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tdata == SYNC_DOLLAR) begin
               state_in = ST_DOLLAR;
            end
         end
         ST_DOLLAR: begin
            if (req_fire) begin
               state_in = (req_tdata == SYNC_M) ? ST_M : ST_IDLE;
            end
         end
         ST_M: begin
            if (req_fire) begin
               state_in = (req_tdata == SYNC_LT) ? ST_SIZE : ST_IDLE;
            end
         end
         ST_SIZE: begin
            if (req_fire) begin
               if (oversize) begin
                  state_in = ST_IDLE;
               end else begin
                  exp_size_in = req_tdata[CNT_W-1:0];
                  count_in    = '0;
                  csum_in     = req_tdata;
                  state_in    = ST_CMD;
               end
            end
         end
         ST_CMD: begin
            if (req_fire) begin
               cmd_in   = req_tdata;
               csum_in  = csum_ff ^ req_tdata;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (req_fire) begin
               if (more) begin
                  csum_in  = csum_ff ^ req_tdata;
                  count_in = cnt_inc;
               end else if (csum_ff == req_tdata) begin
                  // good frame: count becomes the read-back index
                  count_in = '0;
                  state_in = ST_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RD: begin
            state_in = ST_LD;
         end
         ST_LD: begin
            if (out_free) begin
               if (empty_frame || last_k) begin
                  state_in = ST_IDLE;
               end else begin
                  count_in = cnt_inc;
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_out) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in.command_code = cmd_ff;
         rsp_item_in.has_payload  = !empty_frame;
         rsp_item_in.payload_byte = empty_frame ? '0 : rd_data;
         rsp_item_in.byte_index   = empty_frame ? '0 : count_ff[IDX_W-1:0];
         rsp_item_in.last         = empty_frame || last_k;
      end
   end

   always_comb begin
      max_pay_in = max_pay_ff;
      if (csr_valid && csr_ready) begin
         max_pay_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_pay_ff   <= MAX_PAYLOAD_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_pay_ff   <= max_pay_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_size_ff <= exp_size_in;
      count_ff    <= count_in;
      csum_ff     <= csum_in;
      cmd_ff      <= cmd_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.byte_index, rsp_item_ff.payload_byte,
                        rsp_item_ff.command_code};
   assign rsp_tuser  = rsp_item_ff.has_payload;
   assign rsp_tlast  = rsp_item_ff.last;

endmodule

@@ rtl/xcfd_payload_ram.sv @@
// payload buffer: one write port, one read port with registered read data
// depends on xcfd_pkg
module xcfd_payload_ram #(
   parameter int DEPTH  = xcfd_pkg::BUF_DEPTH_DEF,
   parameter int ADDR_W = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [xcfd_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [xcfd_pkg::BYTE_W-1:0] rd_data
);
   import xcfd_pkg::*;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/xcfd_checker.sv @@
// port-level checks for the deframer core, attached by bind
// depends on xcfd_pkg and xor_checked_frame_deframer_core
module xcfd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [xcfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);
   import xcfd_pkg::*;

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // empty frame gives one last beat with zero byte and index
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[21:8] == '0)
      else $error("malformed empty-frame beat");

   // input stays stalled while a burst is still being read back
   a_burst_stalls_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken in the middle of a burst");

endmodule

bind xor_checked_frame_deframer_core xcfd_checker u_xcfd_checker (.*);

@@ tb/tb_xor_checked_frame_deframer_core.sv @@
// self-checking testbench for xor_checked_frame_deframer_core: feeds '$' 'M' '<' frames,
// broken headers and noise, predicts the emitted beats and compares them field by field
// depends on xcfd_pkg and the core module only
module tb_xor_checked_frame_deframer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import xcfd_pkg::*;

   localparam int DEPTH       = BUF_DEPTH_DEF;
   localparam int PHASE_ITEMS = 45;
   localparam int SETTLE      = 8;
   localparam int TAIL        = 20;
   localparam int HOLD_OFF    = 400;
   localparam int STALL_LIMIT = 3000;

   typedef enum logic [2:0] {
      RX_IDLE, RX_DOLLAR, RX_M, RX_SIZE, RX_CMD, RX_DATA
   } rx_state_type;

   // how a stimulus row is checked
   typedef enum logic [1:0] {BY_MODEL, NO_BEAT, ONE_BEAT} row_check_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx;
      row_check_type     check;
      rsp_item_type      beat;
   } dir_row_type;

   localparam rsp_item_type NO_RSP   = '0;
   localparam rsp_item_type EMPTY_FF = '{last: 1'b1, has_payload: 1'b0, byte_index: '0,
                                         payload_byte: '0, command_code: 8'hFF};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data = '0;

   // travels with req_tdata so the scoreboard knows how to check the beat
   row_check_type         row_check = BY_MODEL;
   rsp_item_type          row_beat = NO_RSP;

   // deframer model state
   rx_state_type          rx_state;
   logic [CFG_W-1:0]      max_len;
   logic [6:0]            frame_len;
   logic [6:0]            frame_count;
   logic [BYTE_W-1:0]     frame_sum;
   logic [BYTE_W-1:0]     frame_cmd;
   logic [BYTE_W-1:0]     frame_buf [DEPTH];

   rsp_item_type          frame_beats [$];
   rsp_item_type          due_beats [$];
   int                    errors = 0;
   int                    beats_seen = 0;
   int                    stall_cycles = 0;
   bit                    sender_steady = 1'b0;

   dir_row_type dir_rows [23] = '{
      '{8'hFF,       NO_BEAT,  NO_RSP},   // noise while idle
      '{SYNC_DOLLAR, BY_MODEL, NO_RSP},
      '{SYNC_M,      BY_MODEL, NO_RSP},
      '{SYNC_DOLLAR, BY_MODEL, NO_RSP},   // '$' where '<' belongs drops the header
      '{SYNC_M,      NO_BEAT,  NO_RSP},   // and that '$' did not restart a frame
      '{SYNC_DOLLAR, BY_MODEL, NO_RSP},
      '{8'h00,       NO_BEAT,  NO_RSP},   // wrong 'M'
      '{SYNC_DOLLAR, BY_MODEL, NO_RSP},
      '{SYNC_M,      BY_MODEL, NO_RSP},
      '{SYNC_LT,     BY_MODEL, NO_RSP},
      '{8'h41,       NO_BEAT,  NO_RSP},   // size one above the limit
      '{SYNC_DOLLAR, BY_MODEL, NO_RSP},
      '{SYNC_M,      BY_MODEL, NO_RSP},
      '{SYNC_LT,     BY_MODEL, NO_RSP},
      '{8'h00,       BY_MODEL, NO_RSP},
      '{8'hFF,       BY_MODEL, NO_RSP},
      '{8'hFF,       ONE_BEAT, EMPTY_FF}, // empty frame, good checksum
      '{SYNC_DOLLAR, BY_MODEL, NO_RSP},
      '{SYNC_M,      BY_MODEL, NO_RSP},
      '{SYNC_LT,     BY_MODEL, NO_RSP},
      '{8'h00,       BY_MODEL, NO_RSP},
      '{8'h12,       BY_MODEL, NO_RSP},
      '{8'h00,       NO_BEAT,  NO_RSP}    // checksum should be 12
   };

   xor_checked_frame_deframer_core #(
      .BUF_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int eff_limit();
      return (max_len > DEPTH) ? DEPTH : int'(max_len);
   endfunction

   // advances the parser by one byte; beats of a good frame land in frame_beats
   function automatic void deframe_byte(logic [BYTE_W-1:0] rx);
      rsp_item_type beat;
      frame_beats.delete();
      case (rx_state)
         RX_IDLE: begin
            if (rx == SYNC_DOLLAR) rx_state = RX_DOLLAR;
         end
         RX_DOLLAR: rx_state = (rx == SYNC_M) ? RX_M : RX_IDLE;
         RX_M: rx_state = (rx == SYNC_LT) ? RX_SIZE : RX_IDLE;
         RX_SIZE: begin
            if (int'(rx) > eff_limit()) begin
               rx_state = RX_IDLE;
            end else begin
               frame_len   = rx[6:0];
               frame_count = '0;
               frame_sum   = rx;
               rx_state    = RX_CMD;
            end
         end
         RX_CMD: begin
            frame_cmd = rx;
            frame_sum ^= rx;
            rx_state = RX_DATA;
         end
         default: begin
            if (frame_count < frame_len) begin
               frame_sum ^= rx;
               frame_buf[frame_count[5:0]] = rx;
               frame_count++;
            end else begin
               rx_state = RX_IDLE;
               if (frame_sum == rx) begin
                  if (frame_len == 0) begin
                     beat = '{last: 1'b1, has_payload: 1'b0, byte_index: '0,
                              payload_byte: '0, command_code: frame_cmd};
                     frame_beats.push_back(beat);
                  end
                  for (int k = 0; k < frame_len; k++) begin
                     beat = '{last: (k + 1 == frame_len), has_payload: 1'b1,
                              byte_index: k[5:0], payload_byte: frame_buf[k[5:0]],
                              command_code: frame_cmd};
                     frame_beats.push_back(beat);
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      rsp_item_type want;
      bit moved;
      moved = 1'b0;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            deframe_byte(req_tdata);
            if (row_check == BY_MODEL) begin
               foreach (frame_beats[i]) due_beats.push_back(frame_beats[i]);
            end else if (row_check == ONE_BEAT) begin
               due_beats.push_back(row_beat);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            beats_seen++;
            if (due_beats.size() == 0) begin
               $error("beat with no frame behind it: tdata %h", rsp_tdata);
               errors++;
            end else begin
               want = due_beats.pop_front();
               check_field("command_code", want.command_code, rsp_tdata[7:0]);
               check_field("payload_byte", want.payload_byte, rsp_tdata[15:8]);
               check_field("byte_index", want.byte_index, rsp_tdata[21:16]);
               check_field("tdata_pad", 0, rsp_tdata[23:22]);
               check_field("has_payload", want.has_payload, rsp_tuser);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (csr_valid && csr_ready) moved = 1'b1;
         stall_cycles = moved ? 0 : stall_cycles + 1;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input row_check_type check,
                            input rsp_item_type beat);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_steady || roll < 60) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else if (roll < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      row_check  <= check;
      row_beat   <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_header();
      send_byte(SYNC_DOLLAR, BY_MODEL, NO_RSP);
      send_byte(SYNC_M, BY_MODEL, NO_RSP);
      send_byte(SYNC_LT, BY_MODEL, NO_RSP);
   endtask

   // one well-formed frame most of the time, else noise, a broken header or oversize
   task automatic send_frame(inout int counted);
      int roll;
      int lim;
      int len;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] sum;
      roll = $urandom_range(0, 99);
      lim = eff_limit();
      sender_steady = ($urandom_range(0, 4) == 0);
      if (roll < 5) begin
         b = 8'($urandom_range(0, 255));
         if (b == SYNC_DOLLAR) b = 8'h00;
         send_byte(b, BY_MODEL, NO_RSP);
         counted += 1;
      end else if (roll < 13) begin
         send_byte(SYNC_DOLLAR, BY_MODEL, NO_RSP);
         b = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1)) begin
            if (b == SYNC_M) b = ~b;
            counted += 2;
         end else begin
            send_byte(SYNC_M, BY_MODEL, NO_RSP);
            if (b == SYNC_LT) b = ~b;
            counted += 3;
         end
         send_byte(b, BY_MODEL, NO_RSP);
      end else if (roll < 20) begin
         send_header();
         send_byte(8'($urandom_range(lim + 1, 255)), BY_MODEL, NO_RSP);
         counted += 4;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 80) len = $urandom_range(0, (lim < 6) ? lim : 6);
         else if (roll < 95) len = $urandom_range(0, lim);
         else len = lim;
         send_header();
         sum = 8'(len);
         send_byte(sum, BY_MODEL, NO_RSP);
         b = 8'($urandom_range(0, 255));
         sum ^= b;
         send_byte(b, BY_MODEL, NO_RSP);
         repeat (len) begin
            b = 8'($urandom_range(0, 255));
            sum ^= b;
            send_byte(b, BY_MODEL, NO_RSP);
         end
         if ($urandom_range(0, 99) < 15) sum ^= 8'($urandom_range(1, 255));
         send_byte(sum, BY_MODEL, NO_RSP);
         counted += 6 + len;
      end
   endtask

   task automatic write_max_payload(input logic [CFG_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      max_len = v;
      csr_valid <= 1'b0;
   endtask

   // waits on the clock first so the scoreboard has taken the last beat
   task automatic wait_drained(input int extra);
      @(posedge clock);
      while (due_beats.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   initial begin : rsp_sink
      int roll;
      bit held_off;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         roll = $urandom_range(0, 99);
         if (!held_off && beats_seen >= 80) begin
            // long back-pressure so the core stops taking bytes
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end else if (roll < 55) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else if (roll < 85) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (roll < 95) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(15, 50)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("xor_checked_frame_deframer_core test failed");
      $finish;
   end

   initial begin : stimulus
      logic [CFG_W-1:0] phase_cfg [8];
      int counted;
      phase_cfg = '{7'd127, 7'd0, 7'd64, 7'd1, 7'd63, 7'd9, 7'd100, 7'd0};
      phase_cfg[7] = 7'($urandom_range(0, 127));
      rx_state    = RX_IDLE;
      max_len     = MAX_PAYLOAD_RST;
      frame_len   = '0;
      frame_count = '0;
      frame_sum   = '0;
      frame_cmd   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_max_payload(7'd64);

      foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].check, dir_rows[i].beat);
      req_tvalid <= 1'b0;

      foreach (phase_cfg[p]) begin
         wait_drained(SETTLE);
         write_max_payload(phase_cfg[p]);
         counted = 0;
         while (counted < PHASE_ITEMS) send_frame(counted);
         req_tvalid <= 1'b0;
      end

      wait_drained(TAIL);
      if (errors == 0 && due_beats.size() == 0) begin
         $display("xor_checked_frame_deframer_core test passed");
      end else begin
         $display("xor_checked_frame_deframer_core test failed");
      end
      $finish;
   end

endmodule
